@@ rtl/u8sd_pkg.sv @@
// shared types, constants and a helper function for the utf-8 stream decoder
`timescale 1ns / 1ps
package u8sd_pkg;

   localparam int BYTE_W   = 8;
   localparam int POINT_W  = 21;
   localparam int DUE_W    = 2;
   localparam int LEN_W    = 3;
   localparam int VERD_W   = 2;
   localparam int RSP_DATA_W = 32;

   localparam logic [POINT_W-1:0] CP_MAX  = 21'h10FFFF;
   localparam logic [POINT_W-1:0] SURR_LO = 21'h00D800;
   localparam logic [POINT_W-1:0] SURR_HI = 21'h00DFFF;
   localparam logic [POINT_W-1:0] MIN_LEN2 = 21'h000080;
   localparam logic [POINT_W-1:0] MIN_LEN3 = 21'h000800;
   localparam logic [POINT_W-1:0] MIN_LEN4 = 21'h010000;

   localparam logic [LEN_W-1:0] SEQ_LEN2 = 3'd2;
   localparam logic [LEN_W-1:0] SEQ_LEN3 = 3'd3;
   localparam logic [LEN_W-1:0] SEQ_LEN4 = 3'd4;

   typedef enum logic [VERD_W-1:0] {
      VERDICT_OK    = 2'd0,
      VERDICT_TRUNC = 2'd1,
      VERDICT_BAD   = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [POINT_W-1:0] code_point;
      logic               point_valid;
      verdict_type        verdict;
      logic [DUE_W-1:0]   missing_bytes;
      logic               string_done;
   } result_type;

   function automatic logic [POINT_W-1:0] min_for_length(input logic [LEN_W-1:0] len);
      logic [POINT_W-1:0] m;
      if (len == SEQ_LEN2) begin
         m = MIN_LEN2;
      end else if (len == SEQ_LEN3) begin
         m = MIN_LEN3;
      end else begin
         m = MIN_LEN4;
      end
      return m;
   endfunction

endpackage

@@ rtl/u8sd_input_stage.sv @@
// input register for the incoming byte stream
`timescale 1ns / 1ps
module u8sd_input_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [u8sd_pkg::BYTE_W-1:0] in_byte,
   input  logic                        in_last,
   input  logic                        downstream_ready,
   output logic                        hold_valid,
   output logic [u8sd_pkg::BYTE_W-1:0] hold_byte,
   output logic                        hold_last
);
   import u8sd_pkg::*;

   logic                valid_ff, valid_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                last_ff, last_in;
   logic                load;

   assign in_ready = !valid_ff || downstream_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = in_byte;
         last_in  = in_last;
      end else if (downstream_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;
   assign hold_last  = last_ff;

endmodule

@@ rtl/u8sd_decode.sv @@
// sequence state and single-pass decode of one byte
`timescale 1ns / 1ps
module u8sd_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [u8sd_pkg::BYTE_W-1:0] in_byte,
   input  logic                        in_last,
   output logic                        fire,
   output u8sd_pkg::result_type        result
);
   import u8sd_pkg::*;

   logic [POINT_W-1:0] partial_ff, partial_in;
   logic [DUE_W-1:0]   due_ff, due_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               failed_ff, failed_in;
   logic [POINT_W-1:0] acc;
   logic [DUE_W-1:0]   due_dec;
   logic               have_point;
   logic [POINT_W-1:0] point;
   logic               bad_value;

   always_comb begin
      partial_in = partial_ff;
      due_in     = due_ff;
      len_in     = len_ff;
      failed_in  = failed_ff;
      have_point = 1'b0;
      point      = '0;
      acc        = {partial_ff[POINT_W-7:0], in_byte[5:0]};
      due_dec    = due_ff - 2'd1;
      bad_value  = (acc > CP_MAX) || ((acc >= SURR_LO) && (acc <= SURR_HI)) ||
                   (acc < min_for_length(len_ff));

      if (!failed_ff) begin
         if (due_ff == '0) begin
            unique case (in_byte) inside
               [8'h00:8'h7F]: begin
                  have_point = 1'b1;
                  point      = {{(POINT_W-BYTE_W){1'b0}}, in_byte};
               end
               [8'hC0:8'hDF]: begin
                  partial_in = {{(POINT_W-5){1'b0}}, in_byte[4:0]};
                  due_in     = 2'd1;
                  len_in     = SEQ_LEN2;
               end
               [8'hE0:8'hEF]: begin
                  partial_in = {{(POINT_W-4){1'b0}}, in_byte[3:0]};
                  due_in     = 2'd2;
                  len_in     = SEQ_LEN3;
               end
               [8'hF0:8'hF7]: begin
                  partial_in = {{(POINT_W-3){1'b0}}, in_byte[2:0]};
                  due_in     = 2'd3;
                  len_in     = SEQ_LEN4;
               end
               default: begin
                  failed_in = 1'b1;
               end
            endcase
         end else if (in_byte[7:6] != 2'b10) begin
            failed_in = 1'b1;
         end else begin
            partial_in = acc;
            due_in     = due_dec;
            if (due_dec == '0) begin
               if (bad_value) begin
                  failed_in = 1'b1;
               end else begin
                  have_point = 1'b1;
                  point      = acc;
               end
               partial_in = '0;
               len_in     = '0;
            end
         end
      end

      fire                 = have_point || in_last;
      result.code_point    = point;
      result.point_valid   = have_point;
      result.verdict       = VERDICT_OK;
      result.missing_bytes = '0;
      result.string_done   = in_last;
      if (in_last) begin
         if (failed_in) begin
            result.verdict = VERDICT_BAD;
         end else if (due_in != '0) begin
            result.verdict       = VERDICT_TRUNC;
            result.missing_bytes = due_in;
         end
         partial_in = '0;
         due_in     = '0;
         len_in     = '0;
         failed_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         due_ff     <= '0;
         len_ff     <= '0;
         failed_ff  <= 1'b0;
      end else if (step) begin
         partial_ff <= partial_in;
         due_ff     <= due_in;
         len_ff     <= len_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

@@ rtl/u8sd_output_stage.sv @@
// result register on the outgoing word stream
`timescale 1ns / 1ps
module u8sd_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  u8sd_pkg::result_type load_result,
   output logic                 ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output u8sd_pkg::result_type out_result
);
   import u8sd_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign ready = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = load_result;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// top level of the utf-8 stream decoder and validator
//
//   channel   dir   tdata                         tuser          tlast
//   req_      in    in_byte[7:0]                  -              last_byte
//   rsp_      out   code_point[20:0] verdict[22:21]
//                   missing_bytes[24:23] zero pad  point_valid    string_done
//
// one word per cycle sustained while rsp_tready stays high; a byte is held in the input register
// and its result then sits in the result register
// synchronous active-high reset clears the sequence state and both valid flags
// a stall on rsp_tready holds the result register and then the input register
// bytes that give no result leave the input register without touching rsp_
`timescale 1ns / 1ps
module utf8_stream_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [u8sd_pkg::BYTE_W-1:0]       req_tdata,  // in_byte
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [u8sd_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // code_point, verdict, missing_bytes
   output logic                              rsp_tuser,  // point_valid
   output logic                              rsp_tlast   // string_done
);
   import u8sd_pkg::*;

   logic              hold_valid;
   logic [BYTE_W-1:0] hold_byte;
   logic              hold_last;
   logic              out_stage_ready;
   logic              step;
   logic              fire;
   result_type        dec_result;
   result_type        rsp_result;

   u8sd_input_stage u_input (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .in_byte          (req_tdata),
      .in_last          (req_tlast),
      .downstream_ready (out_stage_ready),
      .hold_valid       (hold_valid),
      .hold_byte        (hold_byte),
      .hold_last        (hold_last)
   );

   assign step = hold_valid && out_stage_ready;

   u8sd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (hold_byte),
      .in_last (hold_last),
      .fire    (fire),
      .result  (dec_result)
   );

   u8sd_output_stage u_output (
      .clock       (clock),
      .reset       (reset),
      .load        (step && fire),
      .load_result (dec_result),
      .ready       (out_stage_ready),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (rsp_result)
   );

   assign rsp_tdata = {{(RSP_DATA_W-POINT_W-VERD_W-DUE_W){1'b0}},
                       rsp_result.missing_bytes,
                       rsp_result.verdict,
                       rsp_result.code_point};
   assign rsp_tuser = rsp_result.point_valid;
   assign rsp_tlast = rsp_result.string_done;

   // a word without a code point only closes a string
   a_nopoint_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_result.code_point == '0))
      else $error("word without code point not at string end");

   // verdict and missing count only on the closing word
   a_verdict_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_result.verdict == VERDICT_OK) &&
                                   (rsp_result.missing_bytes == '0))
      else $error("verdict reported before string end");

   // emitted code points are unicode scalar values
   a_scalar_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_result.code_point <= CP_MAX) &&
         ((rsp_result.code_point < SURR_LO) || (rsp_result.code_point > SURR_HI)))
      else $error("code point outside scalar range");

   // missing bytes go with a truncation verdict only
   a_missing_trunc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_result.missing_bytes != '0) |->
         rsp_result.verdict == VERDICT_TRUNC)
      else $error("missing bytes without truncation");

endmodule
